// ===== rtl/stx_rx_pkg.sv =====
package stx_rx_pkg;

    // line characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ACK = 8'h06;

    // register reset value
    localparam logic [7:0] TRY_LIMIT_RESET = 8'd10;

    // result queue geometry
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    // receive phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LEN   = 3'd1,
        PH_PAY   = 3'd2,
        PH_CHK   = 3'd3,
        PH_REPLY = 3'd4
    } phase_t;

    // result codes
    typedef enum logic [2:0] {
        EV_PAYLOAD = 3'd0,
        EV_ACK     = 3'd1,
        EV_NAK     = 3'd2,
        EV_ENQ     = 3'd3,
        EV_FAIL    = 3'd4
    } event_t;

    // input command codes
    typedef enum logic {
        CMD_BYTE    = 1'b0,
        CMD_TIMEOUT = 1'b1
    } cmd_t;

    // one result item
    typedef struct packed {
        event_t     event_res;
        logic [7:0] value;
        logic       last;
    } result_t;

    // push request into the result queue
    typedef struct packed {
        logic    push_one;
        logic    push_two;
        result_t first;
        result_t second;
    } push_t;

endpackage

// ===== rtl/stx_rx_queue.sv =====
module stx_rx_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  stx_rx_pkg::push_t  push,
    output logic               room_two,
    output logic               head_valid,
    input  logic               head_ready,
    output stx_rx_pkg::result_t head
);
    import stx_rx_pkg::*;

    result_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic [QCNT_W-1:0]  push_cnt;
    logic               pop;

    // status towards both sides
    assign head_valid = (count_reg != '0);
    assign room_two   = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign head       = mem_reg[rd_ptr_reg];
    assign pop        = head_valid && head_ready;

    // pointer and fill arithmetic
    always_comb begin
        push_cnt    = push.push_two ? QCNT_W'(2) : (push.push_one ? QCNT_W'(1) : '0);
        wr_ptr_next = wr_ptr_reg + push_cnt[QPTR_W-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_cnt - (pop ? QCNT_W'(1) : QCNT_W'(0));
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push.push_one) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.push_two) begin
            mem_reg[wr_ptr_reg + QPTR_W'(1)] <= push.second;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // fill never overflows
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // a second result always comes with a first
    a_push_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push_two |-> push.push_one)
        else $error("second result pushed without first");

    // pushing needs room for a pair
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push_one |-> room_two)
        else $error("push without room");

    // the queue holds a valid head the cycle after a push
    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push_one |=> head_valid)
        else $error("pushed item not visible");

endmodule

// ===== rtl/stx_frame_receiver.sv =====
// results: each result item is written into a registered result queue when its input item is accepted
// throughput: one input item per cycle while the result queue has room for two; an item
//   giving two results (NAK then ENQ) pushes both into a four-entry result queue
// reset: synchronous active-low aresetn returns the phase to idle, clears the
//   counters, empties the queue and sets the try limit to 10
module stx_frame_receiver (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [7:0] m_value,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_try_limit
);
    import stx_rx_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] frame_length_reg;
    logic [7:0] frame_length_next;
    logic [7:0] bytes_remaining_reg;
    logic [7:0] bytes_remaining_next;
    logic [7:0] running_xor_reg;
    logic [7:0] running_xor_next;
    logic [8:0] try_count_reg;
    logic [8:0] try_count_next;
    logic [8:0] try_sum;
    logic [7:0] try_limit_reg;
    logic       accept;
    logic       is_byte;
    logic [7:0] remaining_dec;
    push_t      push;
    result_t    head;
    logic       room_two;

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_ready   = room_two;
    assign accept    = s_valid && s_ready;
    assign is_byte   = (cmd_t'(s_cmd) == CMD_BYTE);

    assign remaining_dec = bytes_remaining_reg - 8'd1;
    assign try_sum = try_count_reg
                   + ((is_byte && s_rx_byte == CH_ACK) ? 9'd1 : 9'd2);

    // next phase and frame state
    always_comb begin
        phase_next           = phase_reg;
        frame_length_next    = frame_length_reg;
        bytes_remaining_next = bytes_remaining_reg;
        running_xor_next     = running_xor_reg;
        try_count_next       = try_count_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    phase_next = (is_byte && s_rx_byte == CH_STX) ? PH_LEN : PH_REPLY;
                end
                PH_LEN: begin
                    if (is_byte) begin
                        frame_length_next    = s_rx_byte;
                        bytes_remaining_next = s_rx_byte;
                        running_xor_next     = s_rx_byte;
                        phase_next = (s_rx_byte == 8'd0) ? PH_CHK : PH_PAY;
                    end else begin
                        phase_next = PH_REPLY;
                    end
                end
                PH_PAY: begin
                    if (is_byte) begin
                        running_xor_next     = running_xor_reg ^ s_rx_byte;
                        bytes_remaining_next = remaining_dec;
                        if (remaining_dec == 8'd0) begin
                            phase_next = PH_CHK;
                        end
                    end else begin
                        phase_next = PH_REPLY;
                    end
                end
                PH_CHK: begin
                    if (is_byte && s_rx_byte == running_xor_reg) begin
                        try_count_next = '0;
                        phase_next     = PH_IDLE;
                    end else begin
                        phase_next = PH_REPLY;
                    end
                end
                PH_REPLY: begin
                    phase_next     = PH_IDLE;
                    try_count_next = (try_sum >= {1'b0, try_limit_reg}) ? 9'd0 : try_sum;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // results of the accepted item
    always_comb begin
        push.push_one         = 1'b0;
        push.push_two         = 1'b0;
        push.first.event_res  = EV_ENQ;
        push.first.value      = 8'd0;
        push.first.last       = 1'b1;
        push.second.event_res = EV_ENQ;
        push.second.value     = 8'd0;
        push.second.last      = 1'b1;
        if (accept) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    push.push_one = !(is_byte && s_rx_byte == CH_STX);
                end
                PH_LEN: begin
                    push.push_one = !is_byte;
                end
                PH_PAY: begin
                    push.push_one = 1'b1;
                    if (is_byte) begin
                        push.first.event_res = EV_PAYLOAD;
                        push.first.value     = s_rx_byte;
                    end
                end
                PH_CHK: begin
                    push.push_one = 1'b1;
                    if (is_byte && s_rx_byte == running_xor_reg) begin
                        push.first.event_res = EV_ACK;
                        push.first.value     = frame_length_reg;
                    end else if (is_byte) begin
                        push.push_two        = 1'b1;
                        push.first.event_res = EV_NAK;
                        push.first.last      = 1'b0;
                    end
                end
                PH_REPLY: begin
                    if (try_sum >= {1'b0, try_limit_reg}) begin
                        push.push_one        = 1'b1;
                        push.first.event_res = EV_FAIL;
                    end
                end
                default: begin
                    push.push_one = 1'b0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            frame_length_reg    <= '0;
            bytes_remaining_reg <= '0;
            running_xor_reg     <= '0;
            try_count_reg       <= '0;
            try_limit_reg       <= TRY_LIMIT_RESET;
        end else begin
            phase_reg           <= phase_next;
            frame_length_reg    <= frame_length_next;
            bytes_remaining_reg <= bytes_remaining_next;
            running_xor_reg     <= running_xor_next;
            try_count_reg       <= try_count_next;
            if (cfg_valid && cfg_ready) begin
                try_limit_reg <= cfg_try_limit;
            end
        end
    end

    // result queue
    stx_rx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room_two   (room_two),
        .head_valid (m_valid),
        .head_ready (m_ready),
        .head       (head)
    );

    assign m_event_res = head.event_res;
    assign m_value     = head.value;
    assign m_last      = head.last;

    // a good check byte always returns to idle with the count cleared
    a_ack_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_CHK && is_byte && s_rx_byte == running_xor_reg)
        |=> (phase_reg == PH_IDLE && try_count_reg == 9'd0))
        else $error("good frame did not clear state");

    // the reply phase never lasts past one item
    a_reply_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_REPLY) |=> (phase_reg == PH_IDLE))
        else $error("reply phase not left");

    // payload phase always has bytes left to take
    a_pay_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAY) |-> (bytes_remaining_reg != 8'd0))
        else $error("payload phase with nothing remaining");

endmodule
